>>> hw/rtl/adbkm_pkg.sv
// ----------------------------------------------------------------------------
// adbkm_pkg
// Shared types and constants for the ADB keyboard and mouse controller.
// ----------------------------------------------------------------------------
`default_nettype none

package adbkm_pkg;

  localparam int RING_DEPTH = 16;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  typedef logic [RING_AW-1:0] ptr_t;

  // Event opcodes
  localparam logic [2:0] OP_CMD    = 3'd0;
  localparam logic [2:0] OP_KEY_DN = 3'd1;
  localparam logic [2:0] OP_KEY_UP = 3'd2;
  localparam logic [2:0] OP_MOVE   = 3'd3;
  localparam logic [2:0] OP_BUTTON = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  // ADB command fields
  localparam logic [1:0] CODE_FLUSH = 2'd0;
  localparam logic [1:0] CODE_TALK  = 2'd3;
  localparam logic [1:0] REG_DATA   = 2'd0;
  localparam logic [1:0] REG_ID     = 2'd3;
  localparam logic [3:0] KBD_ADDR      = 4'd2;
  localparam logic [3:0] MOUSE_ADDR    = 4'd3;
  localparam logic [7:0] KBD_HANDLER   = 8'd2;
  localparam logic [7:0] MOUSE_HANDLER = 8'd3;
  localparam logic [7:0] SRQ_BIT       = 8'h20;
  localparam logic [7:0] EMPTY_BYTE    = 8'hFF;

  // What the response stage does with a request
  localparam logic [1:0] RK_NONE = 2'd0;  // plain result, read_data zero
  localparam logic [1:0] RK_READ = 2'd1;  // return one response byte
  localparam logic [1:0] RK_KBD  = 2'd2;  // load response from ring read data
  localparam logic [1:0] RK_LOAD = 2'd3;  // load response from carried bytes

  typedef struct packed {
    logic [2:0]        opcode;
    logic [7:0]        command_byte;
    logic [7:0]        key_code;
    logic signed [15:0] move_dx;
    logic signed [15:0] move_dy;
    logic              pressed;
  } req_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       response_pending;
    logic       service_request;
  } rsp_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       two;      // second keyboard byte comes from the ring
    logic       rd_hit;   // a response byte is left to read
    logic       rd_idx;
    logic       pending;
    logic       srq;
  } resp_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/adbkm_if.sv
// ----------------------------------------------------------------------------
// adbkm_if
// Valid/ready channels for event requests and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface adbkm_req_if import adbkm_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface adbkm_rsp_if import adbkm_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/adbkm_ring.sv
// ----------------------------------------------------------------------------
// adbkm_ring
// Key event memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module adbkm_ring import adbkm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       wr_en,
  input  wire ptr_t       wr_addr,
  input  wire logic [7:0] wr_data,
  input  wire logic       rd_en,
  input  wire ptr_t       rd_addr0,
  input  wire ptr_t       rd_addr1,
  output logic [7:0]      rd_data0,
  output logic [7:0]      rd_data1
);

  logic [7:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/adbkm_resp.sv
// ----------------------------------------------------------------------------
// adbkm_resp
// Response stage: response byte buffer, ring data capture and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module adbkm_resp import adbkm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire resp_cmd_t  cmd,
  input  wire logic [7:0] ring_data0,
  input  wire logic [7:0] ring_data1,
  output logic            ready,
  adbkm_rsp_if.source     rsp
);

  logic       s2_valid;
  resp_cmd_t  s2;
  logic       advance;
  logic [7:0] resp_bytes [2];
  logic [7:0] read_data;
  logic       out_valid;
  rsp_item_t  out_item;

  assign advance = s2_valid && (!out_valid || rsp.ready);
  assign ready   = !s2_valid || !out_valid || rsp.ready;

  always_comb begin
    unique case (s2.kind)
      RK_READ: read_data = s2.rd_hit ? resp_bytes[s2.rd_idx] : EMPTY_BYTE;
      RK_NONE, RK_KBD, RK_LOAD: read_data = 8'h00;
      default: read_data = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (load) begin
      s2_valid <= 1'b1;
    end else if (advance) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2 <= cmd;
    end
  end

  // Ring read data is valid while the keyboard talk sits in this stage
  always_ff @(posedge clk) begin
    if (advance && s2.kind == RK_KBD) begin
      resp_bytes[0] <= ring_data0;
      resp_bytes[1] <= s2.two ? ring_data1 : EMPTY_BYTE;
    end else if (advance && s2.kind == RK_LOAD) begin
      resp_bytes[0] <= s2.b0;
      resp_bytes[1] <= s2.b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.read_data        <= read_data;
      out_item.response_pending <= s2.pending;
      out_item.service_request  <= s2.srq;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

endmodule

`default_nettype wire

>>> hw/rtl/adb_keyboard_mouse_controller.sv
// A result passes the response stage register, then the output register.
// One request per cycle while the response stage is ready; the ring memory
// reads head and head+1 in the accept cycle for the response stage to use.
// Reset (rst, synchronous): clears ring pointers, mouse accumulators, flags,
// response length and index, and the pipeline valids. The ring memory and
// response bytes are not cleared.
// ----------------------------------------------------------------------------
// adb_keyboard_mouse_controller
// ADB keyboard and mouse device: event decode, control state and ring access.
// ----------------------------------------------------------------------------
`default_nettype none

module adb_keyboard_mouse_controller import adbkm_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  adbkm_req_if.sink   req,
  adbkm_rsp_if.source rsp
);

  localparam ptr_t PTR_LAST = ptr_t'(RING_DEPTH - 1);

  ptr_t              ring_head, ring_head_next;
  ptr_t              ring_tail, ring_tail_next;
  logic signed [15:0] acc_dx, acc_dx_next;
  logic signed [15:0] acc_dy, acc_dy_next;
  logic              button_down, button_down_next;
  logic              moved_flag, moved_flag_next;
  logic [1:0]        resp_length, resp_length_next;
  logic [1:0]        resp_index, resp_index_next;

  logic       accept;
  logic       s2_ready;
  resp_cmd_t  cmd;
  logic       wr_en;
  logic [7:0] wr_data;
  ptr_t       head_inc;
  ptr_t       head_inc2;
  ptr_t       tail_inc;
  logic [7:0] ring_data0;
  logic [7:0] ring_data1;
  logic [3:0] addr;
  logic [1:0] code;
  logic [1:0] regn;
  logic       ring_has;
  logic       ring_has2;
  logic       mouse_has;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic [16:0] sum;
    sum = {a[15], a} + {b[15], b};
    if (sum[16] != sum[15]) begin
      return sum[16] ? 16'sh8000 : 16'sh7FFF;
    end
    return sum[15:0];
  endfunction

  function automatic logic [6:0] clamp7(input logic signed [15:0] v);
    if (v < -16'sd64) begin
      return 7'h40;
    end else if (v > 16'sd63) begin
      return 7'h3F;
    end
    return v[6:0];
  endfunction

  assign accept    = req.valid && req.ready;
  assign req.ready = s2_ready;

  assign head_inc  = ptr_inc(ring_head);
  assign head_inc2 = ptr_inc(head_inc);
  assign tail_inc  = ptr_inc(ring_tail);
  assign addr      = req.payload.command_byte[7:4];
  assign code      = req.payload.command_byte[3:2];
  assign regn      = req.payload.command_byte[1:0];
  assign ring_has  = ring_head != ring_tail;
  assign ring_has2 = head_inc != ring_tail;
  assign mouse_has = moved_flag || button_down;
  assign wr_data   = {req.payload.opcode == OP_KEY_UP, req.payload.key_code[6:0]};

  always_comb begin
    ring_head_next   = ring_head;
    ring_tail_next   = ring_tail;
    acc_dx_next      = acc_dx;
    acc_dy_next      = acc_dy;
    button_down_next = button_down;
    moved_flag_next  = moved_flag;
    resp_length_next = resp_length;
    resp_index_next  = resp_index;
    wr_en            = 1'b0;
    cmd              = '0;
    cmd.kind         = RK_NONE;

    unique case (req.payload.opcode)
      OP_CMD: begin
        resp_length_next = 2'd0;
        resp_index_next  = 2'd0;
        priority if (req.payload.command_byte[3:0] == 4'h0) begin
          ring_head_next   = '0;
          ring_tail_next   = '0;
          acc_dx_next      = '0;
          acc_dy_next      = '0;
          button_down_next = 1'b0;
          moved_flag_next  = 1'b0;
        end else if (code == CODE_FLUSH) begin
          if (addr == KBD_ADDR) begin
            ring_head_next = '0;
            ring_tail_next = '0;
          end else if (addr == MOUSE_ADDR) begin
            acc_dx_next     = '0;
            acc_dy_next     = '0;
            moved_flag_next = 1'b0;
          end
        end else if (code == CODE_TALK) begin
          if (addr == KBD_ADDR && regn == REG_DATA && ring_has) begin
            cmd.kind         = RK_KBD;
            cmd.two          = ring_has2;
            ring_head_next   = ring_has2 ? head_inc2 : head_inc;
            resp_length_next = 2'd2;
          end else if (addr == KBD_ADDR && regn == REG_ID) begin
            cmd.kind         = RK_LOAD;
            cmd.b0           = (ring_has ? SRQ_BIT : 8'h00) | {4'h0, KBD_ADDR};
            cmd.b1           = KBD_HANDLER;
            resp_length_next = 2'd2;
          end else if (addr == MOUSE_ADDR && regn == REG_DATA && mouse_has) begin
            cmd.kind         = RK_LOAD;
            cmd.b0           = {!button_down, clamp7(acc_dy)};
            cmd.b1           = {1'b1, clamp7(acc_dx)};
            acc_dx_next      = '0;
            acc_dy_next      = '0;
            moved_flag_next  = 1'b0;
            resp_length_next = 2'd2;
          end else if (addr == MOUSE_ADDR && regn == REG_ID) begin
            cmd.kind         = RK_LOAD;
            cmd.b0           = (mouse_has ? SRQ_BIT : 8'h00) | {4'h0, MOUSE_ADDR};
            cmd.b1           = MOUSE_HANDLER;
            resp_length_next = 2'd2;
          end
        end
      end
      OP_KEY_DN, OP_KEY_UP: begin
        // drop the key when the ring is full
        if (tail_inc != ring_head) begin
          wr_en          = 1'b1;
          ring_tail_next = tail_inc;
        end
      end
      OP_MOVE: begin
        acc_dx_next     = sat_add(acc_dx, req.payload.move_dx);
        acc_dy_next     = sat_add(acc_dy, req.payload.move_dy);
        moved_flag_next = 1'b1;
      end
      OP_BUTTON: begin
        button_down_next = req.payload.pressed;
        moved_flag_next  = 1'b1;
      end
      OP_READ: begin
        cmd.kind = RK_READ;
        if (resp_index < resp_length) begin
          cmd.rd_hit      = 1'b1;
          cmd.rd_idx      = resp_index[0];
          resp_index_next = resp_index + 2'd1;
        end
      end
      default: begin
      end
    endcase

    cmd.pending = resp_index_next < resp_length_next;
    cmd.srq     = (ring_head_next != ring_tail_next) || moved_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head   <= '0;
      ring_tail   <= '0;
      acc_dx      <= '0;
      acc_dy      <= '0;
      button_down <= 1'b0;
      moved_flag  <= 1'b0;
      resp_length <= 2'd0;
      resp_index  <= 2'd0;
    end else if (accept) begin
      ring_head   <= ring_head_next;
      ring_tail   <= ring_tail_next;
      acc_dx      <= acc_dx_next;
      acc_dy      <= acc_dy_next;
      button_down <= button_down_next;
      moved_flag  <= moved_flag_next;
      resp_length <= resp_length_next;
      resp_index  <= resp_index_next;
    end
  end

  adbkm_ring u_ring (
    .clk      (clk),
    .wr_en    (accept && wr_en),
    .wr_addr  (ring_tail),
    .wr_data  (wr_data),
    .rd_en    (accept),
    .rd_addr0 (ring_head),
    .rd_addr1 (head_inc),
    .rd_data0 (ring_data0),
    .rd_data1 (ring_data1)
  );

  adbkm_resp u_resp (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .cmd        (cmd),
    .ring_data0 (ring_data0),
    .ring_data1 (ring_data1),
    .ready      (s2_ready),
    .rsp        (rsp)
  );

`ifndef SYNTH
  a_move_sets_flag: assert property (@(posedge clk) disable iff (rst)
    accept && req.payload.opcode == OP_MOVE |=> moved_flag)
    else $error("mouse move did not set moved flag");

  a_reset_cmd: assert property (@(posedge clk) disable iff (rst)
    accept && req.payload.opcode == OP_CMD && req.payload.command_byte[3:0] == 4'h0
    |=> ring_head == ring_tail && acc_dx == 16'sd0 && acc_dy == 16'sd0
        && !button_down && !moved_flag && resp_length == 2'd0)
    else $error("reset command left state behind");

  a_resp_index: assert property (@(posedge clk) disable iff (rst)
    resp_index <= resp_length)
    else $error("response index ran past response length");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    accept && wr_en |=> ring_tail != ring_head)
    else $error("key push left ring looking empty");
`endif

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ADB keyboard and mouse controller. A short
// table of directed events runs first, then a random mix of key bursts,
// mouse motion, Talk and Flush commands with read-back and noise. Every
// accepted result is checked against its table entry or a behavioral predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import adbkm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam logic [1:0] CODE_SPARE  = 2'd1;
  localparam logic [1:0] CODE_LISTEN = 2'd2;
  localparam logic [1:0] REG_AUX1    = 2'd1;
  localparam logic [1:0] REG_AUX2    = 2'd2;

  localparam logic [7:0] CMD_RESET       = {4'h0, CODE_FLUSH, REG_DATA};
  localparam logic [7:0] CMD_KBD_DATA    = {KBD_ADDR, CODE_TALK, REG_DATA};
  localparam logic [7:0] CMD_KBD_ID      = {KBD_ADDR, CODE_TALK, REG_ID};
  localparam logic [7:0] CMD_KBD_REG2    = {KBD_ADDR, CODE_TALK, REG_AUX2};
  localparam logic [7:0] CMD_KBD_FLUSH   = {KBD_ADDR, CODE_FLUSH, REG_AUX1};
  localparam logic [7:0] CMD_KBD_LISTEN  = {KBD_ADDR, CODE_LISTEN, REG_ID};
  localparam logic [7:0] CMD_KBD_SPARE   = {KBD_ADDR, CODE_SPARE, REG_AUX1};
  localparam logic [7:0] CMD_MOUSE_DATA  = {MOUSE_ADDR, CODE_TALK, REG_DATA};
  localparam logic [7:0] CMD_MOUSE_ID    = {MOUSE_ADDR, CODE_TALK, REG_ID};
  localparam logic [7:0] CMD_MOUSE_FLUSH = {MOUSE_ADDR, CODE_FLUSH, REG_AUX1};

  localparam int DIR_ROWS      = 27;
  localparam int RANDOM_EVENTS = 620;
  localparam int CALM_TAIL     = 100;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    req_item_t ev;
    bit        typed;
    rsp_item_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst;

  adbkm_req_if req ();
  adbkm_rsp_if rsp ();

  adb_keyboard_mouse_controller i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  // Device shadow state
  logic [7:0]         key_fifo [RING_DEPTH];
  ptr_t               kf_rd;
  ptr_t               kf_wr;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic               btn_held;
  logic               motion_seen;
  logic [7:0]         reply_byte [2];
  logic [1:0]         reply_len;
  logic [1:0]         reply_pos;

  rsp_item_t  results_due [$];
  req_item_t  random_events [$];
  table_row_t dir_tab [DIR_ROWS];
  int         useful_count = 0;
  int         fail_count = 0;
  bit         bursts_on = 1'b1;

  function automatic void clear_device();
    kf_rd = '0;
    kf_wr = '0;
    acc_x = '0;
    acc_y = '0;
    btn_held = 1'b0;
    motion_seen = 1'b0;
    reply_len = '0;
    reply_pos = '0;
  endfunction

  function automatic void load_reply(logic [7:0] b0, logic [7:0] b1);
    reply_byte[0] = b0;
    reply_byte[1] = b1;
    reply_len = 2'd2;
    reply_pos = 2'd0;
  endfunction

  // Wrap at the ring depth
  function automatic ptr_t ptr_step(ptr_t p);
    return (p == ptr_t'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic signed [15:0] sat_add(logic signed [15:0] a,
                                                 logic signed [15:0] b);
    int s;
    s = int'(a) + int'(b);
    if (s > 32767) return 16'sh7FFF;
    if (s < -32768) return 16'sh8000;
    return s[15:0];
  endfunction

  function automatic logic [6:0] clamp7(logic signed [15:0] v);
    if (v < -16'sd64) return 7'h40;
    if (v > 16'sd63) return 7'h3F;
    return v[6:0];
  endfunction

  // Advance the shadow device by one event and return the result it gives.
  function automatic rsp_item_t predict_event(req_item_t ev);
    rsp_item_t  r;
    logic [3:0] addr;
    logic [1:0] code;
    logic [1:0] regn;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       has;
    ptr_t       nxt;
    r = '0;
    addr = ev.command_byte[7:4];
    code = ev.command_byte[3:2];
    regn = ev.command_byte[1:0];
    case (ev.opcode)
      OP_CMD: begin
        reply_len = '0;
        reply_pos = '0;
        if (ev.command_byte[3:0] == 4'h0) begin
          clear_device();
        end else if (code == CODE_FLUSH) begin
          if (addr == KBD_ADDR) begin
            kf_rd = '0;
            kf_wr = '0;
          end else if (addr == MOUSE_ADDR) begin
            acc_x = '0;
            acc_y = '0;
            motion_seen = 1'b0;
          end
        end else if (code == CODE_TALK) begin
          if (addr == KBD_ADDR) begin
            if (regn == REG_DATA && kf_rd != kf_wr) begin
              b0 = key_fifo[kf_rd];
              kf_rd = ptr_step(kf_rd);
              b1 = EMPTY_BYTE;
              if (kf_rd != kf_wr) begin
                b1 = key_fifo[kf_rd];
                kf_rd = ptr_step(kf_rd);
              end
              load_reply(b0, b1);
            end else if (regn == REG_ID) begin
              load_reply((kf_rd != kf_wr ? SRQ_BIT : 8'h00) | {4'h0, KBD_ADDR},
                         KBD_HANDLER);
            end
          end else if (addr == MOUSE_ADDR) begin
            has = motion_seen || btn_held;
            if (regn == REG_DATA && has) begin
              load_reply({~btn_held, clamp7(acc_y)}, {1'b1, clamp7(acc_x)});
              acc_x = '0;
              acc_y = '0;
              motion_seen = 1'b0;
            end else if (regn == REG_ID) begin
              load_reply((has ? SRQ_BIT : 8'h00) | {4'h0, MOUSE_ADDR}, MOUSE_HANDLER);
            end
          end
        end
      end
      OP_KEY_DN, OP_KEY_UP: begin
        nxt = ptr_step(kf_wr);
        // drop the event when the ring is full
        if (nxt != kf_rd) begin
          key_fifo[kf_wr] = {ev.opcode == OP_KEY_UP, ev.key_code[6:0]};
          kf_wr = nxt;
        end
      end
      OP_MOVE: begin
        acc_x = sat_add(acc_x, ev.move_dx);
        acc_y = sat_add(acc_y, ev.move_dy);
        motion_seen = 1'b1;
      end
      OP_BUTTON: begin
        btn_held = ev.pressed;
        motion_seen = 1'b1;
      end
      OP_READ: begin
        if (reply_pos < reply_len && reply_pos < 2'd2) begin
          r.read_data = reply_byte[reply_pos[0]];
          reply_pos = reply_pos + 1'b1;
        end else begin
          r.read_data = EMPTY_BYTE;
        end
      end
      default: ;
    endcase
    r.response_pending = reply_pos < reply_len;
    r.service_request = (kf_rd != kf_wr) || motion_seen;
    return r;
  endfunction

  function automatic req_item_t rand_event(logic [2:0] op);
    req_item_t ev;
    ev.opcode = op;
    ev.command_byte = 8'($urandom());
    ev.key_code = 8'($urandom());
    ev.move_dx = 16'($urandom());
    ev.move_dy = 16'($urandom());
    ev.pressed = 1'($urandom());
    return ev;
  endfunction

  function automatic void queue_event(req_item_t ev);
    random_events.push_back(ev);
    if (ev.opcode <= OP_READ) useful_count++;
  endfunction

  function automatic void queue_cmd(logic [7:0] cmd);
    req_item_t ev;
    ev = rand_event(OP_CMD);
    ev.command_byte = cmd;
    queue_event(ev);
  endfunction

  function automatic void queue_reads(int hi);
    int n;
    n = $urandom_range(0, hi);
    repeat (n) queue_event(rand_event(OP_READ));
  endfunction

  function automatic logic signed [15:0] rand_delta();
    int v;
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return 16'($urandom());
      default: begin
        v = int'($urandom_range(0, 200)) - 100;
        return 16'(v);
      end
    endcase
  endfunction

  // Append one well-formed sequence, or a little noise.
  function automatic void add_scenario();
    req_item_t  ev;
    logic [3:0] addr;
    int         n;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = $urandom_range(1, 18);
        repeat (n) queue_event(rand_event($urandom_range(0, 1) ? OP_KEY_DN : OP_KEY_UP));
        n = $urandom_range(0, 3);
        repeat (n) begin
          queue_cmd(CMD_KBD_DATA);
          queue_reads(3);
        end
      end
      3, 4, 5: begin
        n = $urandom_range(0, 4);
        repeat (n) begin
          ev = rand_event(OP_MOVE);
          ev.move_dx = rand_delta();
          ev.move_dy = rand_delta();
          queue_event(ev);
        end
        if ($urandom_range(0, 2) == 0) queue_event(rand_event(OP_BUTTON));
        queue_cmd($urandom_range(0, 3) == 0 ? CMD_MOUSE_ID : CMD_MOUSE_DATA);
        queue_reads(3);
      end
      6: begin
        addr = $urandom_range(0, 1) ? KBD_ADDR : MOUSE_ADDR;
        queue_cmd({addr, CODE_TALK, REG_ID});
        queue_reads(3);
      end
      7: begin
        case ($urandom_range(0, 2))
          0: addr = KBD_ADDR;
          1: addr = MOUSE_ADDR;
          default: addr = 4'($urandom());
        endcase
        queue_cmd({addr, CODE_FLUSH, 2'($urandom_range(1, 3))});
      end
      8: queue_event(rand_event(3'($urandom())));
      default: begin
        queue_cmd({4'($urandom()), CODE_TALK, 2'($urandom())});
        queue_reads(3);
      end
    endcase
  endfunction

  task automatic drive_event(input req_item_t ev, input bit typed, input rsp_item_t want);
    rsp_item_t model;
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= ev;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    model = predict_event(ev);
    results_due.push_back(typed ? want : model);
  endtask

  // Result sink: ready in random runs, with stall bursts while enabled.
  initial begin : sink_side
    forever begin
      if (bursts_on && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    rsp_item_t want;
    rsp_item_t got;
    if (rst === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      got = rsp.payload;
      if (results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result: data=%02h pend=%b srq=%b",
                   got.read_data, got.response_pending, got.service_request);
      end else begin
        want = results_due.pop_front();
        if (got.read_data !== want.read_data ||
            got.response_pending !== want.response_pending ||
            got.service_request !== want.service_request) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch: want data=%02h pend=%b srq=%b, got data=%02h pend=%b srq=%b",
                     want.read_data, want.response_pending, want.service_request,
                     got.read_data, got.response_pending, got.service_request);
        end
      end
    end
  end

  initial begin : watchdog
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main_seq
    rsp_item_t none;
    int        i;
    none = '0;
    clear_device();
    dir_tab = '{
      '{'{OP_READ,   8'h00,           8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{EMPTY_BYTE, 1'b0, 1'b0}},
      '{'{OP_CMD,    CMD_KBD_ID,      8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{8'h00, 1'b1, 1'b0}},
      '{'{OP_READ,   8'h00,           8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{8'h02, 1'b1, 1'b0}},
      '{'{OP_READ,   8'h00,           8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{KBD_HANDLER, 1'b0, 1'b0}},
      '{'{OP_READ,   8'h00,           8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{EMPTY_BYTE, 1'b0, 1'b0}},
      '{'{OP_CMD,    CMD_MOUSE_ID,    8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{8'h00, 1'b1, 1'b0}},
      '{'{OP_KEY_DN, 8'h00,           8'hFF, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_KEY_UP, 8'hFF,           8'h00, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, none},
      '{'{OP_CMD,    CMD_KBD_DATA,    8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_READ,   8'h00,           8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_READ,   8'h00,           8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_MOVE,   8'h00,           8'h00, 16'h7FFF, 16'h8000, 1'b0}, 1'b0, none},
      '{'{OP_MOVE,   8'h00,           8'h00, 16'h7FFF, 16'h8000, 1'b0}, 1'b0, none},
      '{'{OP_BUTTON, 8'h00,           8'h00, 16'h0000, 16'h0000, 1'b1}, 1'b0, none},
      '{'{OP_CMD,    CMD_MOUSE_DATA,  8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_READ,   8'h00,           8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_READ,   8'h00,           8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_CMD,    CMD_MOUSE_FLUSH, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_CMD,    CMD_KBD_LISTEN,  8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_CMD,    CMD_KBD_SPARE,   8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_KEY_DN, 8'h00,           8'h41, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_CMD,    CMD_KBD_FLUSH,   8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_SPARE6, 8'hFF,           8'hFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, none},
      '{'{OP_SPARE7, 8'h00,           8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_CMD,    CMD_MOUSE_DATA,  8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, none},
      '{'{OP_CMD,    CMD_RESET,       8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{8'h00, 1'b0, 1'b0}},
      '{'{OP_CMD,    CMD_KBD_REG2,    8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{8'h00, 1'b0, 1'b0}}
    };
    req.valid <= 1'b0;
    req.payload <= '0;
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++)
      drive_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].want);

    while (useful_count < RANDOM_EVENTS) add_scenario();
    for (i = 0; i < random_events.size(); i++) begin
      // run the tail at full rate on both sides
      if (i >= random_events.size() - CALM_TAIL) bursts_on = 1'b0;
      drive_event(random_events[i], 1'b0, none);
    end
    req.valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
